// ===== sv/tea_pkg.sv =====
// Shared types, constants and the round function for the TEA block cipher.
package tea_pkg;

    // Round constant added to the running sum in every round
    localparam logic [31:0] TeaDelta = 32'h9e37_79b9;

    // Width of the configuration register index
    localparam int CfgIndexWidth = 8;

    // Configuration register indexes
    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_KEY_WORD0 = 8'd0,
        CFG_KEY_WORD1 = 8'd1,
        CFG_KEY_WORD2 = 8'd2,
        CFG_KEY_WORD3 = 8'd3
    } cfg_index_t;

    // Operation codes
    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    // Input beat
    typedef struct packed {
        logic        op;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic        last_block;
    } blk_t;

    // Result beat
    typedef struct packed {
        logic [31:0] first_result;
        logic [31:0] second_result;
        logic        last_result;
    } res_t;

    // 128-bit key as four words
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } key_t;

    // Working state carried down the pipeline
    typedef struct packed {
        logic        op;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } stage_t;

    // TEA mixing term
    function automatic logic [31:0] tea_mix(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

// ===== sv/tea_key_regs.sv =====
// Key register file written through the configuration channel.
module tea_key_regs
    import tea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0]              cfg_data,
    output key_t                     key
);

    key_t key_reg;
    key_t key_next;

    // Always take configuration beats
    assign cfg_ready = 1'b1;

    // Decode the register index; drop writes beyond the list
    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_WORD0: key_next.w0 = cfg_data;
                CFG_KEY_WORD1: key_next.w1 = cfg_data;
                CFG_KEY_WORD2: key_next.w2 = cfg_data;
                CFG_KEY_WORD3: key_next.w3 = cfg_data;
                default:       key_next = key_reg;
            endcase
        end
    end

    // Hold the key words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else
            key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

// ===== sv/tea_round_stage.sv =====
// One half-round of TEA, encrypt or decrypt, with its pipeline register.
module tea_round_stage
    import tea_pkg::*;
#(
    parameter int ROUNDS = 32,
    parameter int HALF   = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  key_t   key,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn_data
);

    // Round number and the sums it uses in each direction
    localparam int          Round   = HALF / 2;
    localparam logic        SecondHalf = (HALF % 2) == 1;
    localparam logic [63:0] EncProd = 64'(TeaDelta) * 64'(Round + 1);
    localparam logic [63:0] DecProd = 64'(TeaDelta) * 64'(ROUNDS - Round);
    localparam logic [31:0] EncSum  = EncProd[31:0];
    localparam logic [31:0] DecSum  = DecProd[31:0];

    logic   valid_reg;
    logic   valid_next;
    stage_t data_reg;
    stage_t data_next;
    logic   advance;

    // Take a new beat when empty or when the current one moves on
    assign advance  = !valid_reg || dn_ready;
    assign up_ready = advance;

    // Half-round: encrypt updates y then z, decrypt undoes z then y
    always_comb
    begin
        data_next = up_data;
        if (up_data.op == OpEncrypt)
        begin
            if (!SecondHalf)
                data_next.y = up_data.y + tea_mix(up_data.z, EncSum, key.w0, key.w1);
            else
                data_next.z = up_data.z + tea_mix(up_data.y, EncSum, key.w2, key.w3);
        end
        else
        begin
            if (!SecondHalf)
                data_next.z = up_data.z - tea_mix(up_data.y, DecSum, key.w2, key.w3);
            else
                data_next.y = up_data.y - tea_mix(up_data.z, DecSum, key.w0, key.w1);
        end
    end

    // Advance the valid bit
    always_comb
    begin
        valid_next = advance ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load payload only when advancing
    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== sv/tea_block_cipher.sv =====
// Top level of the pipelined TEA block cipher with key configuration port.
//
// TEA block cipher, ECB use: each beat on blk carries one 64-bit block and an op
// bit (0 encrypt, 1 decrypt); one result beat leaves on res for every block, in
// order, with the last-block flag copied through. The rounds are unrolled into
// 2*ROUNDS register stages, one half-round each, and a new block can enter
// every cycle while res_stall is low. Each stage forwards when its successor
// has room, so a stalled result lets earlier bubbles close up. The four key
// words are read by the stages as they stand, so write them only while no
// block is in flight; they reset to 0.
module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int ROUNDS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     blk_valid,
    output logic                     blk_stall,
    input  blk_t                     blk_data,
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_t                     res_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0]              cfg_data
);

    localparam int Stages = 2 * ROUNDS;

    key_t   key;
    logic   valid_w [Stages+1];
    logic   ready_w [Stages+1];
    stage_t data_w  [Stages+1];

    tea_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // Feed the first stage from the input beat
    assign valid_w[0]     = blk_valid;
    assign data_w[0].op   = blk_data.op;
    assign data_w[0].y    = blk_data.first_word;
    assign data_w[0].z    = blk_data.second_word;
    assign data_w[0].last = blk_data.last_block;
    assign blk_stall      = !ready_w[0];

    // Chain of half-round stages
    for (genvar i = 0; i < Stages; i++)
    begin : g_stage
        tea_round_stage #(
            .ROUNDS (ROUNDS),
            .HALF   (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (key),
            .up_valid (valid_w[i]),
            .up_ready (ready_w[i]),
            .up_data  (data_w[i]),
            .dn_valid (valid_w[i+1]),
            .dn_ready (ready_w[i+1]),
            .dn_data  (data_w[i+1])
        );
    end

    // Last stage register is the output register
    assign ready_w[Stages]        = !res_stall;
    assign res_valid              = valid_w[Stages];
    assign res_data.first_result  = data_w[Stages].y;
    assign res_data.second_result = data_w[Stages].z;
    assign res_data.last_result   = data_w[Stages].last;

endmodule
